FILE: hw/rtl/dbvm_pkg.sv
// ----------------------------------------------------------------------------
// dbvm_pkg
// Shared types and constants for the DC bus voltage monitor: value widths,
// register indexes, fault codes and sequencer states.
// ----------------------------------------------------------------------------
package dbvm_pkg;

	localparam int unsigned VAL_W     = 19;
	localparam int unsigned WEIGHT_W  = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned FAULT_W   = 2;

	localparam logic [VAL_W-1:0] VMAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_WEIGHT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_WEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OV_LIMIT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UV_LIMIT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RT_LIMIT        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_UV       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_BUS      = 3'd6;

	localparam logic [WEIGHT_W-1:0] RST_INPUT_WEIGHT    = 9'd256;
	localparam logic [WEIGHT_W-1:0] RST_FEEDBACK_WEIGHT = 9'd0;
	localparam logic [VAL_W-1:0]    RST_OV_LIMIT        = 19'd194560;
	localparam logic [VAL_W-1:0]    RST_UV_LIMIT        = 19'd89600;
	localparam logic [VAL_W-1:0]    RST_RT_LIMIT        = 19'd38400;

	localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_OV   = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_UV   = 2'd2;
	localparam logic [FAULT_W-1:0] FAULT_RT   = 2'd3;

	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_REWIND = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAIN,
		ST_DIODE,
		ST_SCALE,
		ST_RAW,
		ST_INW,
		ST_FILT,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/dc_bus_voltage_monitor.sv
// ----------------------------------------------------------------------------
// dc_bus_voltage_monitor
// Converts DC bus ADC samples to volts, low-pass filters them and checks the
// filtered value against over-, under- and ride-through limits.
// A sample item runs DIV_STEPS shift-and-add passes for the divide by
// 2^ADC_BITS - 1 (two at default), then seven steps (gain, diode, scale, raw,
// input weight, filter, done) around the shared multiplier; a rewind item
// goes straight to done. A new item is accepted only while idle, after the
// previous result has been loaded into the output registers.
// Reset clears raw and filtered state and loads the register defaults.
// ----------------------------------------------------------------------------
module dc_bus_voltage_monitor #(
	parameter int unsigned FRACTION_BITS = 8,
	parameter int unsigned ADC_BITS      = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_write,
	input  logic [dbvm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbvm_pkg::VAL_W-1:0]          cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [ADC_BITS-1:0]                 adc_sample,
	input  logic                                drive_ready,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dbvm_pkg::VAL_W-1:0]          raw_volts,
	output logic [dbvm_pkg::VAL_W-1:0]          filtered_volts,
	output logic [dbvm_pkg::VAL_W-1:0]          reported_volts,
	output logic [dbvm_pkg::FAULT_W-1:0]        fault_code,
	output logic                                trip
);

	localparam int unsigned VAL_W = dbvm_pkg::VAL_W;
	localparam int unsigned WT_W  = dbvm_pkg::WEIGHT_W;

	localparam longint unsigned ONE     = longint'(1) << FRACTION_BITS;
	localparam longint unsigned K_GAIN  = (39178 * ONE + 500) / 1000;
	localparam longint unsigned K_DIODE = (8 * ONE + 5) / 10;
	localparam longint unsigned K_SCALE = (1026 * ONE + 50) / 100;

	localparam int unsigned QW        = FRACTION_BITS + 2;
	localparam int unsigned DIV_STEPS = (QW + ADC_BITS - 1) / ADC_BITS + 1;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
	localparam int unsigned DS_W      = ADC_BITS + FRACTION_BITS + 3;
	localparam int unsigned S_W   = FRACTION_BITS + 7;
	localparam int unsigned MA_W  = (S_W > VAL_W) ? S_W : VAL_W;
	localparam int unsigned MB_W  = FRACTION_BITS + 6;
	localparam int unsigned P_W   = MA_W + MB_W;
	localparam int unsigned ACC_W = VAL_W + 1;

	dbvm_pkg::state_t state_q, state_next;

	logic [WT_W-1:0]  input_weight_q, feedback_weight_q;
	logic [VAL_W-1:0] ov_limit_q, uv_limit_q, rt_limit_q, manual_q;
	logic             ignore_uv_q;

	logic [VAL_W-1:0]    raw_q, filter_q;
	logic                ready_q;
	logic [ADC_BITS+1:0] num_q;
	logic [QW-1:0]       quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [S_W-1:0]      s_q;
	logic [ACC_W-1:0]    acc_q;
	logic [P_W-1:0]      prod_q;

	logic [MA_W-1:0]     mul_a;
	logic [MB_W-1:0]     mul_b;
	logic [DS_W-1:0]     div_sum;
	logic [ADC_BITS+1:0] adc_x3;
	logic [ACC_W:0]      filt_sum;
	logic [VAL_W-1:0]    raw_sat, filt_sat;
	logic                in_fire, out_load;
	logic [dbvm_pkg::FAULT_W-1:0] fault_next;

	assign in_fire = in_valid && in_ready;
	assign adc_x3  = {2'b00, adc_sample} + {1'b0, adc_sample, 1'b0};
	assign div_sum = {1'b0, num_q, {FRACTION_BITS{1'b0}}} + DS_W'(quo_q) + DS_W'(1);

	assign raw_sat  = (|prod_q[P_W-1:FRACTION_BITS+VAL_W]) ? dbvm_pkg::VMAX
		: prod_q[FRACTION_BITS +: VAL_W];
	assign filt_sum = {1'b0, acc_q} + {1'b0, prod_q[8 +: ACC_W]};
	assign filt_sat = (|filt_sum[ACC_W:VAL_W]) ? dbvm_pkg::VMAX : filt_sum[VAL_W-1:0];

	always_comb begin
		if (filter_q > ov_limit_q) begin
			fault_next = dbvm_pkg::FAULT_OV;
		end else if (!ignore_uv_q && filter_q < uv_limit_q) begin
			fault_next = dbvm_pkg::FAULT_UV;
		end else if (ignore_uv_q && filter_q < rt_limit_q) begin
			fault_next = dbvm_pkg::FAULT_RT;
		end else begin
			fault_next = dbvm_pkg::FAULT_NONE;
		end
		if (!ready_q) begin
			fault_next = dbvm_pkg::FAULT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_weight_q    <= dbvm_pkg::RST_INPUT_WEIGHT;
			feedback_weight_q <= dbvm_pkg::RST_FEEDBACK_WEIGHT;
			ov_limit_q        <= dbvm_pkg::RST_OV_LIMIT;
			uv_limit_q        <= dbvm_pkg::RST_UV_LIMIT;
			rt_limit_q        <= dbvm_pkg::RST_RT_LIMIT;
			ignore_uv_q       <= 1'b0;
			manual_q          <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				dbvm_pkg::REG_INPUT_WEIGHT:    input_weight_q    <= cfg_data[WT_W-1:0];
				dbvm_pkg::REG_FEEDBACK_WEIGHT: feedback_weight_q <= cfg_data[WT_W-1:0];
				dbvm_pkg::REG_OV_LIMIT:        ov_limit_q        <= cfg_data;
				dbvm_pkg::REG_UV_LIMIT:        uv_limit_q        <= cfg_data;
				dbvm_pkg::REG_RT_LIMIT:        rt_limit_q        <= cfg_data;
				dbvm_pkg::REG_IGNORE_UV:       ignore_uv_q       <= cfg_data[0];
				dbvm_pkg::REG_MANUAL_BUS:      manual_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			dbvm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_next = (action == dbvm_pkg::ACTION_REWIND) ? dbvm_pkg::ST_DONE
						: dbvm_pkg::ST_DIV;
				end
			end
			dbvm_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_next = dbvm_pkg::ST_GAIN;
				end
			end
			dbvm_pkg::ST_GAIN: begin
				mul_a      = MA_W'(quo_q);
				mul_b      = MB_W'(K_GAIN);
				state_next = dbvm_pkg::ST_DIODE;
			end
			dbvm_pkg::ST_DIODE: begin
				mul_a      = MA_W'(filter_q);
				mul_b      = MB_W'(feedback_weight_q);
				state_next = dbvm_pkg::ST_SCALE;
			end
			dbvm_pkg::ST_SCALE: begin
				mul_a      = MA_W'(s_q);
				mul_b      = MB_W'(K_SCALE);
				state_next = dbvm_pkg::ST_RAW;
			end
			dbvm_pkg::ST_RAW: begin
				state_next = dbvm_pkg::ST_INW;
			end
			dbvm_pkg::ST_INW: begin
				mul_a      = MA_W'(raw_q);
				mul_b      = MB_W'(input_weight_q);
				state_next = dbvm_pkg::ST_FILT;
			end
			dbvm_pkg::ST_FILT: begin
				state_next = dbvm_pkg::ST_DONE;
			end
			dbvm_pkg::ST_DONE: begin
				if (!out_valid || out_ready) begin
					out_load   = 1'b1;
					state_next = dbvm_pkg::ST_IDLE;
				end
			end
			default: state_next = dbvm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= P_W'(mul_a) * P_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= '0;
			filter_q <= '0;
		end else if (in_fire && action == dbvm_pkg::ACTION_REWIND) begin
			filter_q <= raw_q;
		end else if (state_q == dbvm_pkg::ST_RAW) begin
			raw_q <= raw_sat;
		end else if (state_q == dbvm_pkg::ST_FILT) begin
			filter_q <= filt_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ready_q <= drive_ready;
			num_q   <= adc_x3;
			quo_q   <= '0;
			cnt_q   <= CNT_W'(DIV_STEPS - 1);
		end else if (state_q == dbvm_pkg::ST_DIV) begin
			quo_q <= div_sum[ADC_BITS +: QW];
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == dbvm_pkg::ST_DIODE) begin
			s_q <= prod_q[FRACTION_BITS +: S_W] + S_W'(K_DIODE);
		end
		if (state_q == dbvm_pkg::ST_SCALE) begin
			acc_q <= prod_q[8 +: ACC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			raw_volts      <= raw_q;
			filtered_volts <= filter_q;
			reported_volts <= (manual_q != '0) ? manual_q : filter_q;
			fault_code     <= fault_next;
			trip           <= fault_next != dbvm_pkg::FAULT_NONE;
		end
	end

endmodule

FILE: dv/dc_bus_voltage_checker.sv
// ----------------------------------------------------------------------------
// dc_bus_voltage_checker
// Watches the register port and both item channels of the DC bus voltage
// monitor. Mirrors the register file, predicts the raw, filtered and reported
// volts and the fault code of every accepted item, and compares each accepted
// result, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module dc_bus_voltage_checker #(
	parameter int unsigned FRACTION_BITS = 8,
	parameter int unsigned ADC_BITS      = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_write,
	input  logic [dbvm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dbvm_pkg::VAL_W-1:0]     cfg_data,

	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           action,
	input  logic [ADC_BITS-1:0]            adc_sample,
	input  logic                           drive_ready,

	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [dbvm_pkg::VAL_W-1:0]     raw_volts,
	input  logic [dbvm_pkg::VAL_W-1:0]     filtered_volts,
	input  logic [dbvm_pkg::VAL_W-1:0]     reported_volts,
	input  logic [dbvm_pkg::FAULT_W-1:0]   fault_code,
	input  logic                           trip,

	output int                             fail_count,
	output int                             pending_count,
	output int                             checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VAL_W    = dbvm_pkg::VAL_W;
	localparam int unsigned WEIGHT_W = dbvm_pkg::WEIGHT_W;
	localparam int unsigned FAULT_W  = dbvm_pkg::FAULT_W;

	localparam longint unsigned ONE      = 64'd1 << FRACTION_BITS;
	localparam longint unsigned ADC_FULL = (64'd1 << ADC_BITS) - 64'd1;
	localparam longint unsigned K_GAIN   = (64'd39178 * ONE + 64'd500) / 64'd1000;
	localparam longint unsigned K_DIODE  = (64'd8 * ONE + 64'd5) / 64'd10;
	localparam longint unsigned K_SCALE  = (64'd1026 * ONE + 64'd50) / 64'd100;

	typedef struct packed {
		logic [VAL_W-1:0]   raw;
		logic [VAL_W-1:0]   filtered;
		logic [VAL_W-1:0]   reported;
		logic [FAULT_W-1:0] fault;
		logic               trip;
	} bus_reading_t;

	bus_reading_t expected_readings[$];
	bus_reading_t oldest;

	logic [WEIGHT_W-1:0] in_weight   = dbvm_pkg::RST_INPUT_WEIGHT;
	logic [WEIGHT_W-1:0] fb_weight   = dbvm_pkg::RST_FEEDBACK_WEIGHT;
	logic [VAL_W-1:0]    ov_limit    = dbvm_pkg::RST_OV_LIMIT;
	logic [VAL_W-1:0]    uv_limit    = dbvm_pkg::RST_UV_LIMIT;
	logic [VAL_W-1:0]    rt_limit    = dbvm_pkg::RST_RT_LIMIT;
	logic                ignore_uv   = 1'b0;
	logic [VAL_W-1:0]    manual_bus  = '0;
	logic [VAL_W-1:0]    raw_level   = '0;
	logic [VAL_W-1:0]    filt_level  = '0;

	int mismatches = 0;
	int checked    = 0;

	function automatic logic [VAL_W-1:0] clamp_volts(longint unsigned v);
		return (v > dbvm_pkg::VMAX) ? dbvm_pkg::VMAX : v[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] adc_to_volts(logic [ADC_BITS-1:0] adc);
		longint unsigned s;
		s = (64'd3 * 64'(adc) * ONE) / ADC_FULL;
		s = (s * K_GAIN) >> FRACTION_BITS;
		s = s + K_DIODE;
		s = (s * K_SCALE) >> FRACTION_BITS;
		return clamp_volts(s);
	endfunction

	function automatic bus_reading_t predict_reading(logic act, logic [ADC_BITS-1:0] adc,
			logic rdy);
		bus_reading_t r;
		longint unsigned sum;
		if (act == dbvm_pkg::ACTION_SAMPLE) begin
			raw_level = adc_to_volts(adc);
			sum = ((64'(filt_level) * 64'(fb_weight)) >> 8) +
				((64'(raw_level) * 64'(in_weight)) >> 8);
			filt_level = clamp_volts(sum);
		end else begin
			filt_level = raw_level;
		end
		r.raw      = raw_level;
		r.filtered = filt_level;
		r.reported = (manual_bus != '0) ? manual_bus : filt_level;
		r.fault    = dbvm_pkg::FAULT_NONE;
		if (rdy) begin
			if (filt_level > ov_limit)
				r.fault = dbvm_pkg::FAULT_OV;
			else if (!ignore_uv && filt_level < uv_limit)
				r.fault = dbvm_pkg::FAULT_UV;
			else if (ignore_uv && filt_level < rt_limit)
				r.fault = dbvm_pkg::FAULT_RT;
		end
		r.trip = (r.fault != dbvm_pkg::FAULT_NONE);
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned want, logic [VAL_W-1:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_weight  = dbvm_pkg::RST_INPUT_WEIGHT;
			fb_weight  = dbvm_pkg::RST_FEEDBACK_WEIGHT;
			ov_limit   = dbvm_pkg::RST_OV_LIMIT;
			uv_limit   = dbvm_pkg::RST_UV_LIMIT;
			rt_limit   = dbvm_pkg::RST_RT_LIMIT;
			ignore_uv  = 1'b0;
			manual_bus = '0;
			raw_level  = '0;
			filt_level = '0;
			expected_readings.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					dbvm_pkg::REG_INPUT_WEIGHT:    in_weight  = cfg_data[WEIGHT_W-1:0];
					dbvm_pkg::REG_FEEDBACK_WEIGHT: fb_weight  = cfg_data[WEIGHT_W-1:0];
					dbvm_pkg::REG_OV_LIMIT:        ov_limit   = cfg_data;
					dbvm_pkg::REG_UV_LIMIT:        uv_limit   = cfg_data;
					dbvm_pkg::REG_RT_LIMIT:        rt_limit   = cfg_data;
					dbvm_pkg::REG_IGNORE_UV:       ignore_uv  = cfg_data[0];
					dbvm_pkg::REG_MANUAL_BUS:      manual_bus = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected result raw_volts", 0, raw_volts);
				end else begin
					oldest = expected_readings.pop_front();
					checked++;
					if (raw_volts !== oldest.raw)
						report_mismatch("raw_volts", oldest.raw, raw_volts);
					if (filtered_volts !== oldest.filtered)
						report_mismatch("filtered_volts", oldest.filtered, filtered_volts);
					if (reported_volts !== oldest.reported)
						report_mismatch("reported_volts", oldest.reported, reported_volts);
					if (fault_code !== oldest.fault)
						report_mismatch("fault_code", oldest.fault, VAL_W'(fault_code));
					if (trip !== oldest.trip)
						report_mismatch("trip", oldest.trip, VAL_W'(trip));
				end
			end
			if (in_valid && in_ready)
				expected_readings.push_back(predict_reading(action, adc_sample, drive_ready));
		end
		pending_count <= expected_readings.size();
		fail_count    <= mismatches;
		checked_count <= checked;
	end

endmodule

FILE: dv/tb_dc_bus_voltage_monitor.sv
// ----------------------------------------------------------------------------
// tb_dc_bus_voltage_monitor
// Drives ADC sample and rewind items and register settings into the DC bus
// voltage monitor: a directed pass over range ends, filter weights, limits,
// the manual override and ride-through mode, then random items under four
// handshake mixes and one long output hold-off. A checker scores the results.
// ----------------------------------------------------------------------------
module tb_dc_bus_voltage_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VAL_W     = dbvm_pkg::VAL_W;
	localparam int unsigned WEIGHT_W  = dbvm_pkg::WEIGHT_W;
	localparam int unsigned FAULT_W   = dbvm_pkg::FAULT_W;
	localparam int unsigned CFG_IDX_W = dbvm_pkg::CFG_IDX_W;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 20;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [11:0] ADC_TOP = '1;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [VAL_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic                 action      = dbvm_pkg::ACTION_SAMPLE;
	logic [11:0]          adc_sample  = '0;
	logic                 drive_ready = 1'b0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [VAL_W-1:0]     raw_volts;
	logic [VAL_W-1:0]     filtered_volts;
	logic [VAL_W-1:0]     reported_volts;
	logic [FAULT_W-1:0]   fault_code;
	logic                 trip;

	int fail_count;
	int pending_count;
	int checked_count;

	int send_idle_pct    = 0;
	int recv_stall_pct   = 0;
	logic hold_off_req   = 1'b0;
	int hold_offs        = 0;
	int items_sent       = 0;
	int rewinds_sent     = 0;
	int ready_sent       = 0;
	int settings_applied = 0;

	dc_bus_voltage_monitor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.adc_sample     (adc_sample),
		.drive_ready    (drive_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.raw_volts      (raw_volts),
		.filtered_volts (filtered_volts),
		.reported_volts (reported_volts),
		.fault_code     (fault_code),
		.trip           (trip)
	);

	dc_bus_voltage_checker bus_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.adc_sample     (adc_sample),
		.drive_ready    (drive_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.raw_volts      (raw_volts),
		.filtered_volts (filtered_volts),
		.reported_volts (reported_volts),
		.fault_code     (fault_code),
		.trip           (trip),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	always #5ns clk = ~clk;

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				hold_offs++;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic send_item(logic act, logic [11:0] adc, logic rdy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		adc_sample  <= adc;
		drive_ready <= rdy;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (act == dbvm_pkg::ACTION_REWIND)
			rewinds_sent++;
		if (rdy)
			ready_sent++;
	endtask

	function automatic logic [VAL_W-1:0] pick_level(int unsigned lo, int unsigned hi);
		case ($urandom_range(7))
			0: return '0;
			1: return dbvm_pkg::VMAX;
			default: return VAL_W'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic randomize_settings();
		logic [WEIGHT_W-1:0] iw;
		logic [WEIGHT_W-1:0] fw;
		case ($urandom_range(3))
			0: begin
				iw = dbvm_pkg::RST_INPUT_WEIGHT;
				fw = '0;
			end
			1: begin
				iw = WEIGHT_W'($urandom_range(1, 256));
				fw = 9'd256 - iw;
			end
			2: begin
				iw = WEIGHT_W'($urandom_range(511));
				fw = WEIGHT_W'($urandom_range(511));
			end
			default: begin
				iw = WEIGHT_W'($urandom_range(16, 64));
				fw = 9'd256 - iw;
			end
		endcase
		write_reg(dbvm_pkg::REG_INPUT_WEIGHT, VAL_W'(iw));
		write_reg(dbvm_pkg::REG_FEEDBACK_WEIGHT, VAL_W'(fw));
		write_reg(dbvm_pkg::REG_OV_LIMIT, pick_level(100000, 320000));
		write_reg(dbvm_pkg::REG_UV_LIMIT, pick_level(0, 150000));
		write_reg(dbvm_pkg::REG_RT_LIMIT, pick_level(0, 100000));
		write_reg(dbvm_pkg::REG_IGNORE_UV, VAL_W'($urandom_range(1)));
		write_reg(dbvm_pkg::REG_MANUAL_BUS, $urandom_range(1) ? pick_level(1, 524287) : '0);
		settings_applied++;
	endtask

	task automatic send_random_items(int count);
		logic act;
		logic [11:0] adc;
		for (int i = 0; i < count; i++) begin
			act = ($urandom_range(9) == 0) ? dbvm_pkg::ACTION_REWIND : dbvm_pkg::ACTION_SAMPLE;
			case ($urandom_range(7))
				0: adc = '0;
				1: adc = ADC_TOP;
				default: adc = 12'($urandom_range(4095));
			endcase
			send_item(act, adc, $urandom_range(3) != 0);
		end
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(dbvm_pkg::ACTION_SAMPLE, '0, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b0);
		send_item(dbvm_pkg::ACTION_REWIND, ADC_TOP, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, 12'd2048, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, 12'hAAA, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, 12'h555, 1'b0);
		send_item(dbvm_pkg::ACTION_REWIND, '0, 1'b0);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_IGNORE_UV, 19'd1);
		send_item(dbvm_pkg::ACTION_SAMPLE, '0, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, 12'd1024, 1'b1);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_IGNORE_UV, '0);
		write_reg(dbvm_pkg::REG_INPUT_WEIGHT, 19'd128);
		write_reg(dbvm_pkg::REG_FEEDBACK_WEIGHT, 19'd128);
		repeat (3) send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		send_item(dbvm_pkg::ACTION_REWIND, '0, 1'b1);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_INPUT_WEIGHT, 19'd511);
		write_reg(dbvm_pkg::REG_FEEDBACK_WEIGHT, 19'd511);
		repeat (2) send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_INPUT_WEIGHT, '0);
		write_reg(dbvm_pkg::REG_FEEDBACK_WEIGHT, '0);
		send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_INPUT_WEIGHT, 19'd256);
		write_reg(dbvm_pkg::REG_MANUAL_BUS, dbvm_pkg::VMAX);
		write_reg(dbvm_pkg::REG_OV_LIMIT, '0);
		write_reg(dbvm_pkg::REG_UV_LIMIT, dbvm_pkg::VMAX);
		write_reg(dbvm_pkg::REG_RT_LIMIT, '0);
		write_reg(REG_UNUSED, dbvm_pkg::VMAX);
		send_item(dbvm_pkg::ACTION_SAMPLE, '0, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		settings_applied++;

		wait_idle();
		write_reg(dbvm_pkg::REG_OV_LIMIT, dbvm_pkg::VMAX);
		write_reg(dbvm_pkg::REG_UV_LIMIT, '0);
		write_reg(dbvm_pkg::REG_RT_LIMIT, dbvm_pkg::VMAX);
		write_reg(dbvm_pkg::REG_IGNORE_UV, 19'd1);
		write_reg(dbvm_pkg::REG_MANUAL_BUS, 19'd1);
		send_item(dbvm_pkg::ACTION_SAMPLE, '0, 1'b1);
		send_item(dbvm_pkg::ACTION_SAMPLE, ADC_TOP, 1'b1);
		settings_applied++;

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct  = 20;
					recv_stall_pct = 20;
				end
			endcase
			wait_idle();
			randomize_settings();
			if (p == 0) begin
				send_random_items(70);
				hold_off_req = 1'b1;
				send_random_items(16);
				send_random_items(70);
			end else begin
				send_random_items(78);
				wait_idle();
				randomize_settings();
				send_random_items(78);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d rewinds, %0d with drive ready) over %0d register settings",
			items_sent, rewinds_sent, ready_sent, settings_applied);
		$display("Checked %0d results across four handshake mixes and %0d output hold-offs",
			checked_count, hold_offs);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
